@@ hw/rtl/gyro_step_distance_tracker_core_assert.svh @@
// Assertion macros for the tracker core
`ifndef GYRO_STEP_DISTANCE_TRACKER_CORE_ASSERT_SVH
`define GYRO_STEP_DISTANCE_TRACKER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define GSDT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define GSDT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define GSDT_ASSERT_NOW(label, clk, rst, ante, cons)
`define GSDT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/gsdt_pkg.sv @@
// Shared types, constants and helpers of the gyro step and distance tracker
package gsdt_pkg;

   localparam int WINDOW_DEF      = 20;
   localparam int DIST_WIDTH_DEF  = 32;
   localparam int QUEUE_DEPTH_DEF = 2;
   localparam int SCALE_MAX       = 270;

   localparam logic [1:0] CSR_FOOT_LENGTH        = 2'd0;
   localparam logic [1:0] CSR_STEP_THRESHOLD     = 2'd1;
   localparam logic [1:0] CSR_ACTIVITY_THRESHOLD = 2'd2;

   localparam logic [3:0] FOOT_LENGTH_RST        = 4'd3;
   localparam logic [8:0] STEP_THRESHOLD_RST     = 9'd150;
   localparam logic [8:0] ACTIVITY_THRESHOLD_RST = 9'd50;

   typedef struct packed {
      logic [3:0] foot_length;
      logic [8:0] step_threshold;
      logic [8:0] activity_threshold;
   } cfg_type;

   typedef struct packed {
      logic [7:0]        step_count;
      logic [25:0]       distance_feet;
      logic signed [7:0] linear_velocity;
   } rsp_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_MIX,
      BK_FILT,
      BK_VEL1,
      BK_VEL2,
      BK_VEL3,
      BK_INC,
      BK_SPLIT,
      BK_ADD
   } back_state_type;

   function automatic int sum_width(input int window);
      return $clog2(window * SCALE_MAX + 1) + 1;
   endfunction

endpackage

@@ hw/rtl/gsdt_front.sv @@
// Front end: accept samples, scale them and sum each window
module gsdt_front #(
   parameter int WINDOW = gsdt_pkg::WINDOW_DEF,
   parameter int SUM_W  = gsdt_pkg::sum_width(gsdt_pkg::WINDOW_DEF)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [15:0]      req_tdata,
   output logic             push,
   output logic [SUM_W-1:0] push_data,
   input  logic             full
);
   import gsdt_pkg::*;

   localparam int CNT_W = $clog2(WINDOW + 1);

   logic                    advance;
   logic                    last;
   logic                    v1_ff, v2_ff, v3_ff;
   logic signed [15:0]      s1_ff;
   logic signed [16:0]      s1_ext;
   logic [16:0]             mag1;
   logic [21:0]             x1;
   logic [15:0]             y2_ff, y2_in;
   logic                    neg2_ff, neg2_in;
   logic [32:0]             p2;
   logic [8:0]              q2;
   logic signed [9:0]       s3_ff, s3_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in, sum_add;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;

   always_comb begin
      s1_ext  = 17'(s1_ff);
      mag1    = s1_ff[15] ? $unsigned(-s1_ext) : $unsigned(s1_ext);
      x1      = {mag1, 5'd0} + 22'(mag1);
      y2_in   = x1[20:5];
      neg2_in = s1_ff[15];
      p2      = 33'(y2_ff) * 33'd67109;
      q2      = p2[31:23];
      s3_in   = neg2_ff ? -$signed({1'b0, q2}) : $signed({1'b0, q2});
      sum_add = sum_ff + SUM_W'(s3_ff);
      last    = (cnt_ff == CNT_W'(WINDOW - 1));
      advance = !(v3_ff && last && full);
      push      = v3_ff && last && !full;
      push_data = sum_add;
      sum_in  = sum_ff;
      cnt_in  = cnt_ff;
      if (v3_ff && advance) begin
         if (last) begin
            sum_in = '0;
            cnt_in = '0;
         end else begin
            sum_in = sum_add;
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         sum_ff <= '0;
         cnt_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
         if (advance) begin
            v1_ff <= req_tvalid;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff   <= $signed(req_tdata);
         y2_ff   <= y2_in;
         neg2_ff <= neg2_in;
         s3_ff   <= s3_in;
      end
   end

endmodule

@@ hw/rtl/gsdt_fifo.sv @@
// Short queue of window sums between front and back end
module gsdt_fifo #(
   parameter int WIDTH = gsdt_pkg::sum_width(gsdt_pkg::WINDOW_DEF),
   parameter int DEPTH = gsdt_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);
   import gsdt_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = entry_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/gsdt_back.sv @@
// Back end: per-window averaging, filtering, velocity, distance and steps
module gsdt_back #(
   parameter int WINDOW     = gsdt_pkg::WINDOW_DEF,
   parameter int DIST_WIDTH = gsdt_pkg::DIST_WIDTH_DEF,
   parameter int SUM_W      = gsdt_pkg::sum_width(gsdt_pkg::WINDOW_DEF)
) (
   input  logic              clock,
   input  logic              reset,
   input  gsdt_pkg::cfg_type cfg,
   input  logic              q_empty,
   input  logic [SUM_W-1:0]  q_data,
   output logic              q_pop,
   input  logic              out_ready,
   output logic              rsp_valid,
   output gsdt_pkg::rsp_type rsp
);
   import gsdt_pkg::*;

   localparam int MAG_W     = SUM_W - 1;
   localparam int AVG_SH    = SUM_W + $clog2(WINDOW);
   localparam int AVG_RCP_W = AVG_SH + 1;
   localparam int AVG_P_W   = MAG_W + AVG_RCP_W;
   localparam logic [63:0] AVG_RCP_L =
      ((64'd1 << AVG_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
   localparam logic [AVG_RCP_W-1:0] AVG_RCP = AVG_RCP_W'(AVG_RCP_L);
   localparam int FW = DIST_WIDTH;
   localparam logic [63:0] DIST_MAX_L = (64'd1 << DIST_WIDTH) - 64'd1;
   localparam logic [FW-1:0] FEET_MAX = FW'(DIST_MAX_L / 64'd100);
   localparam logic [6:0]    REM_MAX  = 7'(DIST_MAX_L % 64'd100);

   back_state_type state_ff, state_in;

   logic signed [SUM_W-1:0] sum_s;
   logic [MAG_W-1:0]        mag_a;
   logic [AVG_P_W-1:0]      avg_p;
   logic [8:0]              avg_q;
   logic signed [9:0]       avg_ff, avg_in;
   logic signed [9:0]       h0_ff, h1_ff, h0_in, h1_in;
   logic signed [11:0]      hsum_ff, hsum_in;
   logic signed [10:0]      x_mix, x_adj;
   logic signed [9:0]       hx;
   logic signed [12:0]      t_ff, t_in;
   logic [10:0]             hmag;
   logic [21:0]             mp;
   logic [11:0]             tmag;
   logic [23:0]             tp;
   logic signed [9:0]       mean_ff, mean_in, filt_ff, filt_in;
   logic [8:0]              fmag;
   logic [12:0]             p1_ff, p1_in;
   logic                    vneg_ff, vneg_in;
   logic [19:0]             y_m;
   logic [15:0]             y_ff, y_in;
   logic [32:0]             vp;
   logic [6:0]              vq;
   logic signed [7:0]       vel_ff, vel_in;
   logic                    vel_pos, active;
   logic [9:0]              inc_ff, inc_in;
   logic [20:0]             ip;
   logic [3:0]              iq_ff, iq_in;
   logic [6:0]              r_add;
   logic [7:0]              rs;
   logic                    carry;
   logic [6:0]              rem_n;
   logic [FW-1:0]           feet_n;
   logic                    sat;
   logic [FW-1:0]           feet_ff, feet_in;
   logic [6:0]              rem_ff, rem_in;
   logic [7:0]              steps_ff, steps_in;
   logic                    latch_ff, latch_in;
   logic signed [9:0]       step_thr, act_thr;
   logic                    out_free;
   logic [63:0]             feet_wide;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   always_comb begin
      sum_s   = $signed(q_data);
      mag_a   = sum_s[SUM_W-1] ? MAG_W'(-sum_s) : MAG_W'(sum_s);
      avg_p   = AVG_P_W'(mag_a) * AVG_P_W'(AVG_RCP);
      avg_q   = avg_p[AVG_SH +: 9];
      avg_in  = sum_s[SUM_W-1] ? -$signed({1'b0, avg_q}) : $signed({1'b0, avg_q});

      hsum_in = 12'(avg_ff) + 12'(h0_ff) + 12'(h1_ff);
      x_mix   = 11'(avg_ff) + 11'(h0_ff);
      x_adj   = x_mix + $signed({10'd0, x_mix[10]});
      hx      = 10'(x_adj >>> 1);
      t_in    = (13'(h0_ff) <<< 3) + (13'(hx) <<< 1);

      hmag    = hsum_ff[11] ? 11'(-hsum_ff) : 11'(hsum_ff);
      mp      = 22'(hmag) * 22'd1366;
      mean_in = hsum_ff[11] ? -$signed({1'b0, mp[20:12]}) : $signed({1'b0, mp[20:12]});
      tmag    = t_ff[12] ? 12'(-t_ff) : 12'(t_ff);
      tp      = 24'(tmag) * 24'd3277;
      filt_in = t_ff[12] ? -$signed({1'b0, tp[23:15]}) : $signed({1'b0, tp[23:15]});

      fmag    = filt_ff[9] ? 9'(-filt_ff) : 9'(filt_ff);
      p1_in   = 13'(fmag) * 13'(cfg.foot_length);
      vneg_in = filt_ff[9];

      y_m     = 20'(p1_ff) * 20'd174;
      y_in    = y_m[19:4];

      vp      = 33'(y_ff) * 33'd107375;
      vq      = vp[32:26];
      vel_in  = vneg_ff ? -$signed({1'b0, vq}) : $signed({1'b0, vq});

      act_thr  = $signed({1'b0, cfg.activity_threshold});
      step_thr = $signed({1'b0, cfg.step_threshold});
      vel_pos  = !vel_ff[7] && (vel_ff != 8'sd0);
      active   = mean_ff > act_thr;
      inc_in   = (vel_pos && active) ? 10'(vel_ff[6:0]) * 10'd14 : 10'd0;

      ip      = 21'(inc_ff) * 21'd1311;
      iq_in   = ip[20:17];

      r_add   = 7'(inc_ff - 10'(iq_ff) * 10'd100);
      rs      = 8'(rem_ff) + 8'(r_add);
      carry   = (rs >= 8'd100);
      rem_n   = carry ? 7'(rs - 8'd100) : 7'(rs);
      feet_n  = feet_ff + FW'(iq_ff) + FW'(carry);
      sat     = (feet_n > FEET_MAX) || ((feet_n == FEET_MAX) && (rem_n > REM_MAX));
   end

   always_comb begin
      state_in     = state_ff;
      q_pop        = 1'b0;
      out_free     = !rsp_valid_ff || out_ready;
      rsp_valid_in = rsp_valid_ff && !out_ready;
      rsp_in       = rsp_ff;
      h0_in        = h0_ff;
      h1_in        = h1_ff;
      feet_in      = feet_ff;
      rem_in       = rem_ff;
      steps_in     = steps_ff;
      latch_in     = latch_ff;
      feet_wide    = 64'(feet_ff);
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               state_in = BK_MIX;
            end
         end
         BK_MIX: begin
            h1_in    = h0_ff;
            h0_in    = avg_ff;
            state_in = BK_FILT;
         end
         BK_FILT:  state_in = BK_VEL1;
         BK_VEL1:  state_in = BK_VEL2;
         BK_VEL2:  state_in = BK_VEL3;
         BK_VEL3:  state_in = BK_INC;
         BK_INC:   state_in = BK_SPLIT;
         BK_SPLIT: state_in = BK_ADD;
         BK_ADD: begin
            if (out_free) begin
               if (sat) begin
                  feet_in = FEET_MAX;
                  rem_in  = REM_MAX;
               end else begin
                  feet_in = feet_n;
                  rem_in  = rem_n;
               end
               if ((filt_ff > step_thr) && !latch_ff) begin
                  steps_in = steps_ff + 8'd1;
                  latch_in = 1'b1;
               end
               if (filt_ff < step_thr) begin
                  latch_in = 1'b0;
               end
               feet_wide              = 64'(feet_in);
               rsp_in.linear_velocity = vel_ff;
               rsp_in.distance_feet   = feet_wide[25:0];
               rsp_in.step_count      = steps_in;
               rsp_valid_in           = 1'b1;
               state_in               = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         h0_ff        <= '0;
         h1_ff        <= '0;
         feet_ff      <= '0;
         rem_ff       <= '0;
         steps_ff     <= '0;
         latch_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         h0_ff        <= h0_in;
         h1_ff        <= h1_in;
         feet_ff      <= feet_in;
         rem_ff       <= rem_in;
         steps_ff     <= steps_in;
         latch_ff     <= latch_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (state_ff == BK_IDLE) begin
         avg_ff <= avg_in;
      end
      if (state_ff == BK_MIX) begin
         hsum_ff <= hsum_in;
         t_ff    <= t_in;
      end
      if (state_ff == BK_FILT) begin
         mean_ff <= mean_in;
         filt_ff <= filt_in;
      end
      if (state_ff == BK_VEL1) begin
         p1_ff   <= p1_in;
         vneg_ff <= vneg_in;
      end
      if (state_ff == BK_VEL2) begin
         y_ff <= y_in;
      end
      if (state_ff == BK_VEL3) begin
         vel_ff <= vel_in;
      end
      if (state_ff == BK_INC) begin
         inc_ff <= inc_in;
      end
      if (state_ff == BK_SPLIT) begin
         iq_ff <= iq_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

@@ hw/rtl/gyro_step_distance_tracker_core.sv @@
// Top level of the gyro step and distance tracker
// Takes one signed gyro sample per beat, scales it, and every WINDOW samples
// emits one result beat with linear velocity, distance in feet and step count.
// The front end accepts one sample per cycle, while the queue is not full,
// through a three-stage scaling pipeline; each finished window sum passes
// through a two-entry queue to a back-end sequencer, one window at a time.
// With WINDOW of 9 or more the block sustains one sample per cycle while each
// result is taken when offered; with a smaller window the back end paces it.
// A result waits in an output register; new samples keep flowing while it is
// held until the queue fills. Configuration writes take effect on the next
// window only if the user writes while idle; the block does not enforce this.
`include "gyro_step_distance_tracker_core_assert.svh"
module gyro_step_distance_tracker_core #(
   parameter int WINDOW     = gsdt_pkg::WINDOW_DEF,
   parameter int DIST_WIDTH = gsdt_pkg::DIST_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] gyro_sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] linear_velocity, [33:8] distance_feet,
                                    // [41:34] step_count
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [8:0]  csr_wdata
);
   import gsdt_pkg::*;

   localparam int SUM_W = sum_width(WINDOW);

   cfg_type          cfg_ff, cfg_in;
   logic             q_push, q_pop, q_full, q_empty;
   logic [SUM_W-1:0] q_wdata, q_rdata;
   rsp_type          rsp_int;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_FOOT_LENGTH:        cfg_in.foot_length        = csr_wdata[3:0];
            CSR_STEP_THRESHOLD:     cfg_in.step_threshold     = csr_wdata;
            CSR_ACTIVITY_THRESHOLD: cfg_in.activity_threshold = csr_wdata;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.foot_length        <= FOOT_LENGTH_RST;
         cfg_ff.step_threshold     <= STEP_THRESHOLD_RST;
         cfg_ff.activity_threshold <= ACTIVITY_THRESHOLD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gsdt_front #(
      .WINDOW (WINDOW),
      .SUM_W  (SUM_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (q_push),
      .push_data  (q_wdata),
      .full       (q_full)
   );

   gsdt_fifo #(
      .WIDTH (SUM_W),
      .DEPTH (QUEUE_DEPTH_DEF)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .full      (q_full),
      .empty     (q_empty)
   );

   gsdt_back #(
      .WINDOW     (WINDOW),
      .DIST_WIDTH (DIST_WIDTH),
      .SUM_W      (SUM_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_data    (q_rdata),
      .q_pop     (q_pop),
      .out_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp       (rsp_int)
   );

   assign rsp_tdata = {6'd0, rsp_int.step_count, rsp_int.distance_feet,
                       rsp_int.linear_velocity};

   `GSDT_ASSERT_NOW(a_no_push_when_full, clock, reset, q_push, !q_full)
   `GSDT_ASSERT_NOW(a_no_pop_when_empty, clock, reset, q_pop, !q_empty)
   `GSDT_ASSERT_NEXT(a_pop_spacing, clock, reset, q_pop, !q_pop)
   `GSDT_ASSERT_NOW(a_velocity_range, clock, reset, rsp_tvalid, (rsp_int.linear_velocity <= 8'sd71) && (rsp_int.linear_velocity >= -8'sd71))

endmodule
